// ===== src/ps2_scancode_line_editor_core_assert.svh =====
// Assertion macros for the PS/2 and UART line editor.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PS2_SCANCODE_LINE_EDITOR_CORE_ASSERT_SVH
`define PS2_SCANCODE_LINE_EDITOR_CORE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PS2LE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define PS2LE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ps2le_pkg.sv =====
// Shared types and constants for the PS/2 and UART line editor.
// No dependencies; imported by the datapath, the controller and the top level.
package ps2le_pkg;

	// Input actions
	localparam logic [1:0] ACT_UART  = 2'd0;
	localparam logic [1:0] ACT_PS2   = 2'd1;
	localparam logic [1:0] ACT_TABLE = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_ECHO  = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ABORT = 2'd3;

	// Output byte source select
	localparam logic [1:0] OSEL_CONST = 2'd0;
	localparam logic [1:0] OSEL_CHAR  = 2'd1;
	localparam logic [1:0] OSEL_STORE = 2'd2;
	localparam logic [1:0] OSEL_LEN   = 2'd3;

	// Scancodes
	localparam logic [7:0] SC_RELEASE = 8'hF0;
	localparam logic [7:0] SC_LSHIFT  = 8'h12;
	localparam logic [7:0] SC_RSHIFT  = 8'h59;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_ETX   = 8'd3;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_C     = 8'd67;
	localparam logic [7:0] CH_CARET = 8'd94;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_DEL   = 8'd127;

	// Key table geometry: two planes of 256 codes
	localparam int TBL_AW    = 9;
	localparam int TBL_DEPTH = 512;

	// Configuration port
	localparam int CFG_W  = 6;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic       table_plane;
		logic [6:0] table_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic       load_item;
		logic       tbl_read;
		logic       tbl_write;
		logic       clr_step;
		logic       set_release;
		logic       clr_release;
		logic       set_shift;
		logic       clr_shift;
		logic       store_write;
		logic       len_inc;
		logic       len_dec;
		logic       len_clr;
		logic       idx_clr;
		logic       idx_adv;
		logic       emit;
		logic [1:0] out_kind;
		logic [1:0] out_sel;
		logic       out_last;
		logic [7:0] out_const;
	} cmd_t;

	typedef struct packed {
		logic       clear_done;
		logic [1:0] action;
		logic       sc_release;
		logic       sc_shift;
		logic       release_pending;
		logic       is_abort;
		logic       is_enter;
		logic       is_bs;
		logic       is_print;
		logic       room;
		logic       len_zero;
		logic       idx_at_len;
		logic       load_ok;
	} status_t;

endpackage

// ===== src/ps2le_datapath.sv =====
// Datapath of the line editor: item register, key table, line store, counters,
// scancode state and the result register. Depends on ps2le_pkg and the assert header.
`include "ps2_scancode_line_editor_core_assert.svh"

module ps2le_datapath #(
	parameter int BUF_MAX = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ps2le_pkg::in_item_t        item,
	input  logic [ps2le_pkg::CFG_W-1:0] buffer_size,
	input  ps2le_pkg::cmd_t            cmd,
	output ps2le_pkg::status_t         status,
	input  logic                       result_stall,
	output logic                       result_valid,
	output ps2le_pkg::out_item_t       result
);
	import ps2le_pkg::*;

	localparam int LW = $clog2(BUF_MAX);

	in_item_t            item_q;
	logic [6:0]          key_table [TBL_DEPTH];
	logic [6:0]          tbl_rd_q;
	logic [6:0]          line_store [BUF_MAX];
	logic [6:0]          store_rd_q;
	logic [LW-1:0]       len_q;
	logic [LW-1:0]       idx_q;
	logic [LW-1:0]       idx_d;
	logic [TBL_AW-1:0]   clr_cnt_q;
	logic                clear_done_q;
	logic                release_q;
	logic                shift_q;
	logic                out_valid_q;
	out_item_t           out_q;
	logic [7:0]          cur_char;
	logic [6:0]          limit;
	logic                tbl_we;
	logic [TBL_AW-1:0]   tbl_wa;
	logic [6:0]          tbl_wd;
	logic [7:0]          out_byte_d;

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
	end

	// Sweep the key table to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			clear_done_q <= 1'b0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == TBL_AW'(TBL_DEPTH - 1)) begin
				clear_done_q <= 1'b1;
			end
		end
	end

	// Key table: one write port shared by the sweep and table writes
	always_comb begin
		tbl_we = cmd.clr_step | cmd.tbl_write;
		if (cmd.clr_step) begin
			tbl_wa = clr_cnt_q;
			tbl_wd = '0;
		end else begin
			tbl_wa = {item_q.table_plane, item_q.data_byte};
			tbl_wd = item_q.table_value;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			key_table[tbl_wa] <= tbl_wd;
		end
		if (cmd.tbl_read) begin
			tbl_rd_q <= key_table[{shift_q, item_q.data_byte}];
		end
	end

	// Track release prefix and shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= 1'b0;
			shift_q   <= 1'b0;
		end else begin
			if (cmd.set_release) begin
				release_q <= 1'b1;
			end else if (cmd.clr_release) begin
				release_q <= 1'b0;
			end
			if (cmd.set_shift) begin
				shift_q <= 1'b1;
			end else if (cmd.clr_shift) begin
				shift_q <= 1'b0;
			end
		end
	end

	// Select the character under edit
	assign cur_char = (item_q.action == ACT_UART) ? item_q.data_byte : {1'b0, tbl_rd_q};

	// Clamp the buffer size to 1..BUF_MAX
	always_comb begin
		if (buffer_size == '0) begin
			limit = 7'd1;
		end else if (7'(buffer_size) > 7'(BUF_MAX)) begin
			limit = 7'(BUF_MAX);
		end else begin
			limit = 7'(buffer_size);
		end
	end

	// Line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.len_clr) begin
			len_q <= '0;
		end else if (cmd.len_inc) begin
			len_q <= len_q + 1'b1;
		end else if (cmd.len_dec) begin
			len_q <= len_q - 1'b1;
		end
	end

	// Emission index; the store reads at the next index so data lines up
	always_comb begin
		if (cmd.idx_clr) begin
			idx_d = '0;
		end else if (cmd.idx_adv) begin
			idx_d = idx_q + 1'b1;
		end else begin
			idx_d = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			idx_q <= idx_d;
		end
	end

	// Line store
	always_ff @(posedge clk) begin
		if (cmd.store_write) begin
			line_store[len_q] <= cur_char[6:0];
		end
		store_rd_q <= line_store[idx_d];
	end

	// Result register
	always_comb begin
		case (cmd.out_sel)
			OSEL_CONST: out_byte_d = cmd.out_const;
			OSEL_CHAR:  out_byte_d = cur_char;
			OSEL_STORE: out_byte_d = {1'b0, store_rd_q};
			OSEL_LEN:   out_byte_d = 8'(len_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.kind     <= cmd.out_kind;
			out_q.out_byte <= out_byte_d;
			out_q.last     <= cmd.out_last;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Status toward the controller
	always_comb begin
		status.clear_done      = clear_done_q;
		status.action          = item_q.action;
		status.sc_release      = (item_q.data_byte == SC_RELEASE);
		status.sc_shift        = (item_q.data_byte == SC_LSHIFT) ||
		                         (item_q.data_byte == SC_RSHIFT);
		status.release_pending = release_q;
		status.is_abort        = (cur_char == CH_ETX) || (cur_char == CH_ESC);
		status.is_enter        = (cur_char == CH_LF) || (cur_char == CH_CR);
		status.is_bs           = (cur_char == CH_BS) || (cur_char == CH_DEL);
		status.is_print        = (cur_char >= CH_SPACE) && (cur_char <= CH_TILDE);
		status.room            = ((7'(len_q) + 7'd1) < limit);
		status.len_zero        = (len_q == '0);
		status.idx_at_len      = (idx_q == len_q);
		status.load_ok         = !out_valid_q || !result_stall;
	end

	`PS2LE_ASSERT_IMPL(a_emit_slot, clk, arst_n, cmd.emit, (!out_valid_q || !result_stall), "result overwritten while stalled")
	`PS2LE_ASSERT_IMPL(a_idx_bound, clk, arst_n, cmd.idx_adv, (idx_q != len_q), "line emission ran past length")
	`PS2LE_ASSERT_IMPL(a_store_room, clk, arst_n, cmd.store_write, ((7'(len_q) + 7'd1) < limit), "character stored without room")
	`PS2LE_ASSERT_NEXT(a_len_clear, clk, arst_n, cmd.len_clr, (len_q == '0), "line length not cleared")

endmodule

// ===== src/ps2le_ctrl.sv =====
// Controller state machine of the line editor: sequences decode, edit and result steps.
// Depends on ps2le_pkg; drives the datapath through cmd_t and reads status_t.
module ps2le_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ps2le_pkg::status_t status,
	output ps2le_pkg::cmd_t    cmd
);
	import ps2le_pkg::*;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_CHAR   = 4'd3;
	localparam logic [3:0] S_AB0    = 4'd4;
	localparam logic [3:0] S_AB1    = 4'd5;
	localparam logic [3:0] S_AB2    = 4'd6;
	localparam logic [3:0] S_AB3    = 4'd7;
	localparam logic [3:0] S_BS0    = 4'd8;
	localparam logic [3:0] S_BS1    = 4'd9;
	localparam logic [3:0] S_BS2    = 4'd10;
	localparam logic [3:0] S_NL     = 4'd11;
	localparam logic [3:0] S_LINE   = 4'd12;
	localparam logic [3:0] S_ECHO   = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != S_IDLE);

	// Set up the command that emits one echo byte; callers use it when the result register is free
	function automatic cmd_t echo(input cmd_t base, input logic [7:0] ch, input logic lst);
		cmd_t c;
		c           = base;
		c.emit      = 1'b1;
		c.out_kind  = KIND_ECHO;
		c.out_sel   = OSEL_CONST;
		c.out_const = ch;
		c.out_last  = lst;
		return c;
	endfunction

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (status.clear_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				unique case (status.action)
					ACT_UART: state_d = S_CHAR;
					ACT_PS2: begin
						if (status.sc_release) begin
							cmd.set_release = 1'b1;
						end else if (status.release_pending) begin
							cmd.clr_release = 1'b1;
							cmd.clr_shift   = status.sc_shift;
						end else if (status.sc_shift) begin
							cmd.set_shift = 1'b1;
						end else begin
							cmd.tbl_read = 1'b1;
							state_d      = S_CHAR;
						end
					end
					ACT_TABLE: cmd.tbl_write = 1'b1;
					default: state_d = S_IDLE;
				endcase
			end
			S_CHAR: begin
				state_d = S_IDLE;
				if (status.is_abort) begin
					cmd.len_clr = 1'b1;
					state_d     = S_AB0;
				end else if (status.is_enter) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_NL;
				end else if (status.is_bs) begin
					if (!status.len_zero) begin
						cmd.len_dec = 1'b1;
						state_d     = S_BS0;
					end
				end else if (status.is_print) begin
					if (status.room) begin
						cmd.store_write = 1'b1;
						cmd.len_inc     = 1'b1;
						state_d         = S_ECHO;
					end
				end
			end
			S_AB0: if (status.load_ok) begin
				cmd     = echo(cmd, CH_CARET, 1'b0);
				state_d = S_AB1;
			end
			S_AB1: if (status.load_ok) begin
				cmd     = echo(cmd, CH_C, 1'b0);
				state_d = S_AB2;
			end
			S_AB2: if (status.load_ok) begin
				cmd     = echo(cmd, CH_LF, 1'b0);
				state_d = S_AB3;
			end
			S_AB3: if (status.load_ok) begin
				cmd          = echo(cmd, CH_NUL, 1'b1);
				cmd.out_kind = KIND_ABORT;
				state_d      = S_IDLE;
			end
			S_BS0: if (status.load_ok) begin
				cmd     = echo(cmd, CH_BS, 1'b0);
				state_d = S_BS1;
			end
			S_BS1: if (status.load_ok) begin
				cmd     = echo(cmd, CH_SPACE, 1'b0);
				state_d = S_BS2;
			end
			S_BS2: if (status.load_ok) begin
				cmd     = echo(cmd, CH_BS, 1'b1);
				state_d = S_IDLE;
			end
			S_NL: if (status.load_ok) begin
				cmd     = echo(cmd, CH_LF, 1'b0);
				state_d = S_LINE;
			end
			// Drain stored characters, then the line end with its length
			S_LINE: if (status.load_ok) begin
				cmd.emit = 1'b1;
				if (status.idx_at_len) begin
					cmd.out_kind = KIND_END;
					cmd.out_sel  = OSEL_LEN;
					cmd.out_last = 1'b1;
					cmd.len_clr  = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.out_kind = KIND_CHAR;
					cmd.out_sel  = OSEL_STORE;
					cmd.idx_adv  = 1'b1;
				end
			end
			S_ECHO: if (status.load_ok) begin
				cmd         = echo(cmd, CH_NUL, 1'b1);
				cmd.out_sel = OSEL_CHAR;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== src/ps2_scancode_line_editor_core.sv =====
// Line editor for UART characters and PS/2 Set 2 scancodes; top level with the APB port.
// Depends on ps2le_pkg, ps2le_ctrl and ps2le_datapath.
// Sequence: an item is taken in idle, decoded in S_DECODE and classified in S_CHAR;
// its first result is then registered by an emit state. A prefix or shift code goes
// back to idle after decode, an ignored character after S_CHAR; results leave one per
// cycle unless stalled. Reset sweeps the 512-entry key table to zero, item_stall high.
module ps2_scancode_line_editor_core #(
	parameter int BUF_MAX = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  ps2le_pkg::in_item_t              item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output ps2le_pkg::out_item_t             result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ps2le_pkg::APB_AW-1:0]     paddr,
	input  logic [ps2le_pkg::APB_DW-1:0]     pwdata,
	output logic [ps2le_pkg::APB_DW-1:0]     prdata,
	output logic                             pready
);
	import ps2le_pkg::*;

	logic [CFG_W-1:0] buffer_size_q;
	logic             reg_hit;
	cmd_t             cmd;
	status_t          status;

	// Configuration register, decoded by word index
	assign reg_hit = (paddr[APB_AW-1:2] == REG_BUFFER_SIZE);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= CFG_W'(32);
		end else if (psel && penable && pwrite && reg_hit) begin
			buffer_size_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = reg_hit ? APB_DW'(buffer_size_q) : '0;

	ps2le_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	ps2le_datapath #(
		.BUF_MAX (BUF_MAX)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.buffer_size  (buffer_size_q),
		.cmd          (cmd),
		.status       (status),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
